/* rtl/core/kdt_pkg.sv */
// Shared types and constants for the keyed device table.
// Entry layout, operation and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package kdt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // One table entry, serial in the low bits.
    typedef struct packed {
        logic [3:0]  link_type;
        logic        banned;
        logic [7:0]  inst_id;
        logic [31:0] model;
        logic [31:0] serial;
    } entry_t;

    localparam int ENTRY_W    = $bits(entry_t);
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 4;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_FIND   = 3'd2,
        KIND_READ   = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_CLEAR,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_SHIFT,
        RD_INDEX
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        rd_sel_t rd_sel;
        logic    scan_next;
        logic    add_update;
        logic    add_insert;
        logic    find_hit;
        logic    miss;
        logic    shift_step;
        logic    shift_done;
        logic    read_hit;
        logic    read_oor;
        logic    clear_all;
        logic    emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic  in_valid;
        kind_t in_kind;
        kind_t cmd_kind;
        logic  scan_end;
        logic  hit;
        logic  shift_end;
        logic  idx_oor;
        logic  out_free;
    } dp_stat_t;

endpackage

/* rtl/core/kdt_ctrl.sv */
// Sequencer for the keyed device table: scan, shift, read, clear, respond.
// Depends on kdt_pkg; drives kdt_datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module kdt_ctrl
    import kdt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_stat_t stat,
    output logic     in_ready,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (stat.in_valid) begin
                    case (stat.in_kind)
                        KIND_ADD, KIND_REMOVE, KIND_FIND: state_next = S_SCAN;
                        KIND_READ:  state_next = S_READ;
                        KIND_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (stat.scan_end) begin
                    state_next = S_RESP;
                end else if (stat.hit) begin
                    state_next = (stat.cmd_kind == KIND_REMOVE) ? S_SHIFT : S_RESP;
                end
            end
            S_SHIFT: begin
                if (stat.shift_end) begin
                    state_next = S_RESP;
                end
            end
            S_READ:  state_next = S_RESP;
            S_CLEAR: state_next = S_RESP;
            S_RESP: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.rd_sel = RD_SCAN;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = stat.in_valid;
            end
            S_SCAN: begin
                cmd.rd_sel = RD_SCAN;
                if (stat.scan_end) begin
                    if (stat.cmd_kind == KIND_ADD) begin
                        cmd.add_insert = 1'b1;
                    end else begin
                        cmd.miss = 1'b1;
                    end
                end else if (stat.hit) begin
                    cmd.add_update = (stat.cmd_kind == KIND_ADD);
                    cmd.find_hit   = (stat.cmd_kind == KIND_FIND);
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SHIFT: begin
                cmd.rd_sel = RD_SHIFT;
                if (stat.shift_end) begin
                    cmd.shift_done = 1'b1;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_READ: begin
                cmd.rd_sel   = RD_INDEX;
                cmd.read_oor = stat.idx_oor;
                cmd.read_hit = !stat.idx_oor;
            end
            S_CLEAR: begin
                cmd.clear_all = 1'b1;
            end
            S_RESP: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/kdt_datapath.sv */
// Entry registers, head and count, command latch, result and output registers.
// Depends on kdt_pkg; sequenced by kdt_ctrl through ctl_cmd_t / dp_stat_t.
`timescale 1ns / 1ps

module kdt_datapath
    import kdt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctl_cmd_t              cmd,
    output dp_stat_t              stat,
    input  logic                  s_valid,
    input  logic [IN_DATA_W-1:0]  s_data,
    input  logic [IN_USER_W-1:0]  s_user,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_DATA_W-1:0] m_data,
    output logic [OUT_USER_W-1:0] m_user
);

    localparam int OUT_PAD_W = OUT_DATA_W - ENTRY_W - CNT_W - 1;

    entry_t                  entry_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [SLOT_W-1:0]       head_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        ptr_reg;

    entry_t                  in_entry_reg;
    logic [SLOT_W-1:0]       idx_reg;
    kind_t                   kind_reg;

    status_t                 res_status_reg;
    logic                    res_update_reg;
    logic                    res_replace_reg;
    entry_t                  res_entry_reg;

    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;
    logic [OUT_USER_W-1:0]   m_user_reg;

    logic [CNT_W-1:0]        ptr_plus;
    logic [CNT_W-1:0]        cnt_dec;
    logic [SLOT_W-1:0]       rd_addr;
    entry_t                  rd_entry;
    logic [SLOT_W-1:0]       head_adv;
    logic                    full_now;

    assign ptr_plus = ptr_reg + 1'b1;
    assign cnt_dec  = count_reg - 1'b1;
    assign full_now = (count_reg == CNT_W'(TABLE_DEPTH));
    assign head_adv = (head_reg == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb begin
        case (cmd.rd_sel)
            RD_SCAN:  rd_addr = ptr_reg[SLOT_W-1:0];
            RD_SHIFT: rd_addr = ptr_plus[SLOT_W-1:0];
            RD_INDEX: rd_addr = idx_reg;
            default:  rd_addr = ptr_reg[SLOT_W-1:0];
        endcase
    end

    // never-written or cleared slots read as zero
    assign rd_entry = valid_reg[rd_addr] ? entry_reg[rd_addr] : '0;

    always_comb begin
        stat.in_valid  = s_valid;
        stat.in_kind   = kind_t'(s_user);
        stat.cmd_kind  = kind_reg;
        stat.scan_end  = (ptr_reg >= count_reg);
        stat.hit       = (rd_entry.serial == in_entry_reg.serial);
        stat.shift_end = (ptr_plus >= count_reg);
        stat.idx_oor   = (CNT_W'(idx_reg) >= count_reg);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.add_update) begin
                valid_reg[ptr_reg[SLOT_W-1:0]] <= 1'b1;
            end
            if (cmd.add_insert) begin
                valid_reg[head_reg] <= 1'b1;
                head_reg            <= head_adv;
                if (!full_now) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.shift_step) begin
                valid_reg[ptr_reg[SLOT_W-1:0]] <= 1'b1;
            end
            if (cmd.shift_done) begin
                valid_reg[cnt_dec[SLOT_W-1:0]] <= 1'b0;
                count_reg                      <= cnt_dec;
                if (head_reg != '0) begin
                    head_reg <= head_reg - 1'b1;
                end else begin
                    head_reg <= cnt_dec[SLOT_W-1:0];
                end
            end
            if (cmd.clear_all) begin
                valid_reg <= '0;
                head_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_entry_reg    <= entry_t'(s_data[ENTRY_W-1:0]);
            idx_reg         <= s_data[ENTRY_W +: SLOT_W];
            kind_reg        <= kind_t'(s_user);
            ptr_reg         <= '0;
            res_status_reg  <= ST_OK;
            res_update_reg  <= 1'b0;
            res_replace_reg <= 1'b0;
            res_entry_reg   <= '0;
        end
        if (cmd.scan_next || cmd.shift_step) begin
            ptr_reg <= ptr_plus;
        end
        if (cmd.add_update) begin
            entry_reg[ptr_reg[SLOT_W-1:0]] <= in_entry_reg;
            res_update_reg                 <= 1'b1;
        end
        if (cmd.add_insert) begin
            entry_reg[head_reg] <= in_entry_reg;
            res_replace_reg     <= full_now;
        end
        if (cmd.shift_step) begin
            entry_reg[ptr_reg[SLOT_W-1:0]] <= rd_entry;
        end
        if (cmd.find_hit || cmd.read_hit) begin
            res_entry_reg <= rd_entry;
        end
        if (cmd.miss) begin
            res_status_reg <= ST_NOT_FOUND;
        end
        if (cmd.read_oor) begin
            res_status_reg <= ST_BAD_INDEX;
        end
        if (cmd.emit) begin
            m_data_reg <= {{OUT_PAD_W{1'b0}}, full_now, count_reg, res_entry_reg};
            m_user_reg <= {res_replace_reg, res_update_reg, res_status_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;

endmodule

/* rtl/core/keyed_device_table_fifo_replace_unit.sv */
// Top level of the keyed device table with oldest-first replacement.
// Depends on kdt_pkg, kdt_ctrl and kdt_datapath.
`timescale 1ns / 1ps

// Usage
//   Slave stream carries one operation per beat: tuser = kind (add/update,
//   remove, find by serial, read by index, clear), tdata = entry and slot.
//   Master stream returns exactly one result beat per operation.
//   One operation is in flight at a time; s_axis_tready is high only while
//   the sequencer is idle, and it may take the next beat while a result
//   still sits in the output register.
// Sequence per operation:
//   add/find  : scan the valid slots in order until a serial hit or the end;
//               an add then updates the hit or inserts at head, then respond
//   remove    : scan; on a hit shift the later slots down and close; respond
//   read/clear: read the slot or clear the table, then respond; unused kinds respond directly
// Rates: the serial compare covers one slot per cycle through the single read
//   mux of the entry registers; the remove shift moves one slot per cycle.
// Reset: aresetn (synchronous, active low) empties the table at once by
//   clearing per-slot valid bits, head and count; no clearing sweep.
// Stall: a held result stays in the output register; the sequencer waits in
//   its response state until the register is free.

module keyed_device_table_fifo_replace_unit
    import kdt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: entry_serial[31:0], entry_model[63:32], entry_instance[71:64],
    //        entry_banned[72], entry_link_type[76:73], slot_index[80:77], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: out_serial[31:0], out_model[63:32], out_instance[71:64],
    //        out_banned[72], out_link_type[76:73], entry_count[81:77],
    //        table_full[82], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0], was_update[2], was_replace[3]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    kdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (dp_stat),
        .in_ready (s_axis_tready),
        .cmd      (ctl_cmd)
    );

    kdt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ctl_cmd),
        .stat    (dp_stat),
        .s_valid (s_axis_tvalid),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_user  (m_axis_tuser)
    );

    // one operation at a time: an accepted beat closes the slave side
    a_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an operation is in flight");

    // result only loaded when the output register can take it
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending beat");

    // failures carry no entry and no add flags
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK)) |->
        ((m_axis_tdata[ENTRY_W-1:0] == '0) && (m_axis_tuser[3:2] == 2'b00)))
        else $error("failed operation returned entry data");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[ENTRY_W +: CNT_W] <= CNT_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

endmodule

/* tb/tb_top.sv */
// Testbench for keyed_device_table_fifo_replace_unit: drives table operations as stream beats.
// Checks every result beat against an in-bench prediction of the table state.
// Depends on kdt_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb_top;
    import kdt_pkg::*;

    localparam int          CLK_HALF        = 10;
    localparam int          RESET_CYCLES    = 11;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam int          SINK_HOLD       = 300;
    localparam int          ITEMS_PER_PHASE = 285;
    localparam int          SERIAL_POOL_N   = 24;
    localparam int          TAIL_CYCLES     = 50;
    // kinds past clear are accepted but do nothing
    localparam logic [2:0]  KIND_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  KIND_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] serial;
        logic [31:0] model;
        logic [7:0]  inst;
        logic        banned;
        logic [3:0]  link;
        logic [3:0]  slot;
    } table_op_t;

    typedef struct packed {
        status_t     status;
        logic        was_update;
        logic        was_replace;
        entry_t      ent;
        logic [4:0]  count;
        logic        full;
    } table_result_t;

    // Table state mirror plus queue of results still owed by the block.
    class device_table_scoreboard;
        entry_t        slots[TABLE_DEPTH];
        int            head;
        int            live_count;
        table_result_t owed_q[$];
        int            errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            head       = 0;
            live_count = 0;
            errors     = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function int find_slot(logic [31:0] key);
            for (int i = 0; i < live_count; i++)
                if (slots[i].serial == key) return i;
            return -1;
        endfunction

        // Apply one accepted operation and queue the result it must produce.
        function void note_request(table_op_t op);
            table_result_t r;
            entry_t        fresh;
            int            pos;
            r = '0;
            fresh.serial    = op.serial;
            fresh.model     = op.model;
            fresh.inst_id   = op.inst;
            fresh.banned    = op.banned;
            fresh.link_type = op.link;
            case (op.kind)
                KIND_ADD: begin
                    pos = find_slot(op.serial);
                    if (pos >= 0) begin
                        slots[pos]   = fresh;
                        r.was_update = 1'b1;
                    end else begin
                        // head may sit past the live range; written there regardless
                        slots[head % TABLE_DEPTH] = fresh;
                        head = (head % TABLE_DEPTH + 1) % TABLE_DEPTH;
                        if (live_count < TABLE_DEPTH) live_count++;
                        else r.was_replace = 1'b1;
                    end
                end
                KIND_REMOVE: begin
                    pos = find_slot(op.serial);
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        for (int j = pos; j + 1 < live_count; j++) slots[j] = slots[j + 1];
                        slots[live_count - 1] = '0;
                        live_count--;
                        if (head > 0) head--;
                        else head = live_count;
                    end
                end
                KIND_FIND: begin
                    pos = find_slot(op.serial);
                    if (pos < 0) r.status = ST_NOT_FOUND;
                    else r.ent = slots[pos];
                end
                KIND_READ: begin
                    if (op.slot >= live_count) r.status = ST_BAD_INDEX;
                    else r.ent = slots[op.slot];
                end
                KIND_CLEAR: begin
                    foreach (slots[i]) slots[i] = '0;
                    head       = 0;
                    live_count = 0;
                end
                default: ;
            endcase
            r.count = live_count[4:0];
            r.full  = (live_count == TABLE_DEPTH);
            owed_q.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
            table_result_t e;
            if (owed_q.size() == 0) begin
                $display("%0t: result beat with nothing owed: expected none, actual tdata=%h tuser=%h",
                         $time, d, u);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            check_field("status",        32'(e.status),        32'(u[1:0]));
            check_field("was_update",    32'(e.was_update),    32'(u[2]));
            check_field("was_replace",   32'(e.was_replace),   32'(u[3]));
            check_field("out_serial",    e.ent.serial,         d[31:0]);
            check_field("out_model",     e.ent.model,          d[63:32]);
            check_field("out_instance",  32'(e.ent.inst_id),   32'(d[71:64]));
            check_field("out_banned",    32'(e.ent.banned),    32'(d[72]));
            check_field("out_link_type", 32'(e.ent.link_type), 32'(d[76:73]));
            check_field("entry_count",   32'(e.count),         32'(d[81:77]));
            check_field("table_full",    32'(e.full),          32'(d[82]));
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    device_table_scoreboard sb;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_token     = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    logic [31:0] serial_pool[SERIAL_POOL_N];

    keyed_device_table_fifo_replace_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off whenever the token moves.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = SINK_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_response(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog: too long without any beat on either side ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL keyed_device_table_fifo_replace_unit");
        $finish;
    end

    function automatic table_op_t make_op(logic [2:0] kind, logic [31:0] serial,
                                          logic [31:0] model, logic [7:0] inst,
                                          logic banned, logic [3:0] link, logic [3:0] slot);
        table_op_t op;
        op.kind   = kind;
        op.serial = serial;
        op.model  = model;
        op.inst   = inst;
        op.banned = banned;
        op.link   = link;
        op.slot   = slot;
        return op;
    endfunction

    function automatic logic [31:0] pick_serial();
        if ($urandom_range(99) < 85) return serial_pool[$urandom_range(SERIAL_POOL_N - 1)];
        return $urandom;
    endfunction

    function automatic table_op_t random_op(logic [2:0] kind);
        return make_op(kind, pick_serial(), $urandom, 8'($urandom), 1'($urandom),
                       4'($urandom), 4'($urandom));
    endfunction

    // Mixed traffic, mostly valid kinds on pooled serials, a little noise.
    function automatic table_op_t mixed_op();
        int        roll;
        table_op_t op;
        roll = $urandom_range(99);
        if (roll < 45)      op = random_op(KIND_ADD);
        else if (roll < 65) op = random_op(KIND_REMOVE);
        else if (roll < 78) op = random_op(KIND_FIND);
        else if (roll < 92) op = random_op(KIND_READ);
        else if (roll < 93) op = random_op(KIND_CLEAR);
        else if (roll < 96) op = random_op(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)));
        else begin
            op        = random_op(3'($urandom));
            op.serial = $urandom;
        end
        return op;
    endfunction

    // One beat on the input side; tvalid stays up into the next call.
    task automatic send_op(input table_op_t op);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, op.slot, op.link, op.banned, op.inst, op.model, op.serial};
        s_axis_tuser  <= op.kind;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_request(op);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_op(make_op(KIND_READ,   32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));      // empty read
        send_op(make_op(KIND_FIND,   32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));      // empty find
        send_op(make_op(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));
        send_op(make_op(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'hF, 4'hF));
        send_op(make_op(KIND_ADD,    32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));
        send_op(make_op(KIND_FIND,   32'hFFFF_FFFF, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));
        send_op(make_op(KIND_ADD, 32'hFFFF_FFFF, 32'h1234_5678, 8'h5A, 1'b0, 4'h6, 4'h0));
        send_op(make_op(KIND_READ,   32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'h1));
        send_op(make_op(KIND_READ,   32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'hF));      // past count
        for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
            send_op(make_op(3'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'hF, 4'hF));
        send_op(make_op(KIND_REMOVE, 32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));
        send_op(make_op(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));
        send_op(make_op(KIND_ADD, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'hA5, 1'b1, 4'h9, 4'h0));
        send_op(make_op(KIND_CLEAR,  32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));
        send_op(make_op(KIND_READ,   32'h0, 32'h0, 8'h0, 1'b0, 4'h0, 4'h0));
        wait_drained();
    endtask

    // Bursts: either a fill run of adds (can reach full and replacement) or mixed traffic.
    task automatic run_phase(input int src_pct, input int sink_pct, input bit long_hold);
        int        counted;
        int        burst;
        table_op_t op;
        src_idle_pct   = src_pct;
        sink_stall_pct <= sink_pct;
        if (long_hold) hold_token <= hold_token + 1;
        counted = 0;
        while (counted < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 20) begin
                burst = $urandom_range(8, 20);
                repeat (burst) begin
                    op = random_op(KIND_ADD);
                    if ($urandom_range(1)) op.serial = $urandom;
                    send_op(op);
                    counted++;
                end
            end else begin
                burst = $urandom_range(10, 30);
                repeat (burst) begin
                    op = mixed_op();
                    send_op(op);
                    if (op.kind <= KIND_CLEAR) counted++;
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        serial_pool[0] = 32'h0;
        serial_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < SERIAL_POOL_N; i++) serial_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_phase(0,  0,  1'b1);
        run_phase(55, 0,  1'b0);
        run_phase(0,  55, 1'b1);
        run_phase(27, 27, 1'b0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS keyed_device_table_fifo_replace_unit");
        else
            $display("FAIL keyed_device_table_fifo_replace_unit");
        $finish;
    end

endmodule
